// ----- design/battery_protection_supervisor_unit_defines.svh -----
// Assertion macros shared by the battery protection supervisor RTL.
`ifndef BATTERY_PROTECTION_SUPERVISOR_UNIT_DEFINES_SVH
`define BATTERY_PROTECTION_SUPERVISOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bps_pkg.sv -----
// Types and constants for the battery protection supervisor.
package bps_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DIS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CHG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_DIS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_CHG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_ZERO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 3'd6;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_TEMP_DIS  = 24'h337F38;
    localparam logic [CFG_W-1:0] RST_TEMP_CHG  = 24'h413A8E;
    localparam logic [CFG_W-1:0] RST_CUR_DIS   = 24'hFAE147;
    localparam logic [CFG_W-1:0] RST_CUR_CHG   = 24'h3F7CED;
    localparam logic [CFG_W-1:0] RST_CUR_ZERO  = 24'h800000;
    localparam logic [CFG_W-1:0] RST_MATCH_WIN = 24'h00FFFF;
    localparam logic [CFG_W-1:0] RST_NOISE     = 24'h000FFF;

    // Request kinds
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_CURRENT = 2'd1;
    localparam logic [1:0] MODE_TEMP    = 2'd2;

    // Monitor sequence steps
    localparam logic [3:0] STEP_CLEAR = 4'd1;
    localparam logic [3:0] STEP_CHIP0 = 4'd3;
    localparam logic [3:0] STEP_CHIP1 = 4'd5;
    localparam logic [3:0] STEP_CHIP2 = 4'd7;
    localparam logic [3:0] STEP_LAST  = 4'd8;

    // Relay bits
    localparam logic [4:0] RL_BATT  = 5'h01;
    localparam logic [4:0] RL_ARRAY = 5'h02;
    localparam logic [4:0] RL_PRE   = 5'h04;
    localparam logic [4:0] RL_MAIN  = 5'h08;
    localparam logic [4:0] RL_EXT   = 5'h10;
    localparam int         RL_PRE_BIT  = 2;
    localparam int         RL_MAIN_BIT = 3;

    // Reported supervisor state codes
    localparam logic [2:0] CODE_SELFCHECK  = 3'd0;
    localparam logic [2:0] CODE_BPSREADY   = 3'd1;
    localparam logic [2:0] CODE_ARRAYREADY = 3'd2;
    localparam logic [2:0] CODE_CANCHECK   = 3'd3;
    localparam logic [2:0] CODE_PRECHARGE  = 3'd4;
    localparam logic [2:0] CODE_NORMAL     = 3'd5;

    typedef enum logic [5:0] {
        ST_SELFCHECK  = 6'b000001,
        ST_BPSREADY   = 6'b000010,
        ST_ARRAYREADY = 6'b000100,
        ST_CANCHECK   = 6'b001000,
        ST_PRECHARGE  = 6'b010000,
        ST_NORMAL     = 6'b100000
    } t_state;

    function automatic logic [2:0] state_code(t_state s);
        logic [2:0] code;
        case (s)
            ST_SELFCHECK:  code = CODE_SELFCHECK;
            ST_BPSREADY:   code = CODE_BPSREADY;
            ST_ARRAYREADY: code = CODE_ARRAYREADY;
            ST_CANCHECK:   code = CODE_CANCHECK;
            ST_PRECHARGE:  code = CODE_PRECHARGE;
            ST_NORMAL:     code = CODE_NORMAL;
            default:       code = CODE_SELFCHECK;
        endcase
        return code;
    endfunction

endpackage

// ----- design/battery_protection_supervisor_unit.sv -----
// Battery protection supervisor: one request in, one status result out, up to one per cycle.
// Usage: each accepted request (status tick, current sample or cell temperature sample)
// produces exactly one result, held while the sink's stall (i_stall) stays high; a new
// request can be taken every cycle while o_stall is low. The request is held in an input
// register, evaluated by one pass of compare logic against the supervisor state, and the
// updated state is the result register that drives the o_ status ports while o_valid is
// high. Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data and must
// only be changed while no request is in flight.
`include "battery_protection_supervisor_unit_defines.svh"

module battery_protection_supervisor_unit #(
    parameter int ADC_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [2:0]                   i_chip_fault_mask,
    input  logic                         i_voltage_read_fail,
    input  logic [ADC_BITS-1:0]          i_adc_sample,
    input  logic [ADC_BITS-1:0]          i_battery_signal,
    input  logic [ADC_BITS-1:0]          i_precharge_signal,
    input  logic [ADC_BITS-1:0]          i_contactor_signal,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [4:0]                   o_relay_mask,
    output logic [2:0]                   o_supervisor_state,
    output logic                         o_kill,
    output logic                         o_precharge_done,
    output logic                         o_contactor_done,
    output logic [2:0]                   o_monitor_error_mask,

    input  logic                         i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CMP_W = (ADC_BITS > bps_pkg::CFG_W) ? ADC_BITS : bps_pkg::CFG_W;

    // Configuration
    logic [bps_pkg::CFG_W-1:0] r_cfg_temp_dis;
    logic [bps_pkg::CFG_W-1:0] r_cfg_temp_chg;
    logic [bps_pkg::CFG_W-1:0] r_cfg_cur_dis;
    logic [bps_pkg::CFG_W-1:0] r_cfg_cur_chg;
    logic [bps_pkg::CFG_W-1:0] r_cfg_cur_zero;
    logic [bps_pkg::CFG_W-1:0] r_cfg_match_win;
    logic [bps_pkg::CFG_W-1:0] r_cfg_noise;

    // Input register
    logic                r_in_valid;
    logic [1:0]          r_in_mode;
    logic [2:0]          r_in_fault;
    logic                r_in_vfail;
    logic [ADC_BITS-1:0] r_in_sample;
    logic [ADC_BITS-1:0] r_in_batt;
    logic [ADC_BITS-1:0] r_in_pre;
    logic [ADC_BITS-1:0] r_in_cont;

    // Supervisor state, also the result register
    logic                r_out_valid;
    bps_pkg::t_state     r_state, n_state;
    logic [3:0]          r_step, n_step;
    logic [2:0]          r_err, n_err;
    logic                r_kill, n_kill;
    logic                r_pre, n_pre;
    logic                r_cc, n_cc;
    logic [4:0]          r_relay, n_relay;
    logic                r_dis, n_dis;
    logic [ADC_BITS-1:0] r_bref, n_bref;

    logic                in_acc;
    logic                adv;
    logic [CMP_W-1:0]    sample;
    logic [CMP_W-1:0]    temp_lim;

    function automatic logic sig_match(
        logic [ADC_BITS-1:0]       sig,
        logic [ADC_BITS-1:0]       ref_val,
        logic [bps_pkg::CFG_W-1:0] win,
        logic [bps_pkg::CFG_W-1:0] floor_val
    );
        logic [ADC_BITS-1:0] diff;
        diff = (ref_val >= sig) ? (ref_val - sig) : (sig - ref_val);
        return (CMP_W'(diff) < CMP_W'(win)) && (CMP_W'(sig) > CMP_W'(floor_val));
    endfunction

    // Result register frees up when empty or taken this cycle
    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_err    = r_err;
        n_kill   = r_kill;
        n_pre    = r_pre;
        n_cc     = r_cc;
        n_relay  = r_relay;
        n_dis    = r_dis;
        n_bref   = r_bref;
        sample   = CMP_W'(r_in_sample);
        temp_lim = r_dis ? CMP_W'(r_cfg_temp_dis) : CMP_W'(r_cfg_temp_chg);

        case (r_in_mode)
            bps_pkg::MODE_TICK: begin
                n_step = r_step + 4'd1;
                n_kill = |r_in_fault;
                case (n_step)
                    bps_pkg::STEP_CLEAR: n_err = '0;
                    bps_pkg::STEP_CHIP0: if (r_in_vfail) n_err[0] = 1'b1;
                    bps_pkg::STEP_CHIP1: if (r_in_vfail) n_err[1] = 1'b1;
                    bps_pkg::STEP_CHIP2: if (r_in_vfail) n_err[2] = 1'b1;
                    default: begin
                        if (n_step > bps_pkg::STEP_LAST) n_step = '0;
                    end
                endcase

                // read errors are tolerated during selfcheck
                if (n_err != '0 && r_state != bps_pkg::ST_SELFCHECK) n_kill = 1'b1;

                if (n_step == bps_pkg::STEP_LAST) begin
                    n_step = '0;
                    case (r_state)
                        bps_pkg::ST_SELFCHECK: begin
                            if (n_kill) begin
                                // withdraw kill and re-init monitors
                                n_kill = 1'b0;
                                n_err  = '0;
                            end else begin
                                n_state = bps_pkg::ST_BPSREADY;
                            end
                        end
                        bps_pkg::ST_BPSREADY: begin
                            n_relay = n_relay | bps_pkg::RL_BATT;
                            n_state = bps_pkg::ST_ARRAYREADY;
                        end
                        bps_pkg::ST_ARRAYREADY: begin
                            n_relay = n_relay | bps_pkg::RL_ARRAY;
                            n_state = bps_pkg::ST_CANCHECK;
                        end
                        bps_pkg::ST_CANCHECK: begin
                            n_state = bps_pkg::ST_PRECHARGE;
                        end
                        bps_pkg::ST_PRECHARGE: begin
                            n_relay = n_relay | bps_pkg::RL_PRE | bps_pkg::RL_EXT;
                            if (r_bref == '0) n_bref = r_in_batt;
                            if (!r_pre) begin
                                if (n_bref != '0) begin
                                    n_pre = sig_match(r_in_pre, n_bref, r_cfg_match_win,
                                                      r_cfg_noise);
                                end
                            end else if (!r_cc) begin
                                n_relay = (n_relay & ~bps_pkg::RL_PRE) | bps_pkg::RL_MAIN;
                                if (n_bref != '0 && sig_match(r_in_cont, n_bref,
                                                              r_cfg_match_win, r_cfg_noise))
                                begin
                                    n_cc    = 1'b1;
                                    n_relay = n_relay & ~bps_pkg::RL_EXT;
                                    n_state = bps_pkg::ST_NORMAL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bps_pkg::MODE_CURRENT: begin
                n_dis = sample >= CMP_W'(r_cfg_cur_zero);
                if (n_dis) begin
                    if (sample >= CMP_W'(r_cfg_cur_dis)) n_kill = 1'b1;
                end else if (sample <= CMP_W'(r_cfg_cur_chg)) begin
                    n_kill = 1'b1;
                end
            end
            bps_pkg::MODE_TEMP: begin
                if (sample <= temp_lim) n_kill = 1'b1;
            end
            default: ;
        endcase

        if (n_kill) begin
            n_relay = '0;
            n_pre   = 1'b0;
            n_cc    = 1'b0;
            n_state = bps_pkg::ST_SELFCHECK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp_dis  <= bps_pkg::RST_TEMP_DIS;
            r_cfg_temp_chg  <= bps_pkg::RST_TEMP_CHG;
            r_cfg_cur_dis   <= bps_pkg::RST_CUR_DIS;
            r_cfg_cur_chg   <= bps_pkg::RST_CUR_CHG;
            r_cfg_cur_zero  <= bps_pkg::RST_CUR_ZERO;
            r_cfg_match_win <= bps_pkg::RST_MATCH_WIN;
            r_cfg_noise     <= bps_pkg::RST_NOISE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bps_pkg::CFG_TEMP_DIS:  r_cfg_temp_dis  <= i_cfg_data;
                bps_pkg::CFG_TEMP_CHG:  r_cfg_temp_chg  <= i_cfg_data;
                bps_pkg::CFG_CUR_DIS:   r_cfg_cur_dis   <= i_cfg_data;
                bps_pkg::CFG_CUR_CHG:   r_cfg_cur_chg   <= i_cfg_data;
                bps_pkg::CFG_CUR_ZERO:  r_cfg_cur_zero  <= i_cfg_data;
                bps_pkg::CFG_MATCH_WIN: r_cfg_match_win <= i_cfg_data;
                bps_pkg::CFG_NOISE:     r_cfg_noise     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= bps_pkg::ST_SELFCHECK;
            r_step      <= '0;
            r_err       <= '0;
            r_kill      <= 1'b0;
            r_pre       <= 1'b0;
            r_cc        <= 1'b0;
            r_relay     <= '0;
            r_dis       <= 1'b0;
            r_bref      <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (adv) begin
                r_state <= n_state;
                r_step  <= n_step;
                r_err   <= n_err;
                r_kill  <= n_kill;
                r_pre   <= n_pre;
                r_cc    <= n_cc;
                r_relay <= n_relay;
                r_dis   <= n_dis;
                r_bref  <= n_bref;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_mode   <= i_mode;
            r_in_fault  <= i_chip_fault_mask;
            r_in_vfail  <= i_voltage_read_fail;
            r_in_sample <= i_adc_sample;
            r_in_batt   <= i_battery_signal;
            r_in_pre    <= i_precharge_signal;
            r_in_cont   <= i_contactor_signal;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_relay_mask         = r_relay;
    assign o_supervisor_state   = bps_pkg::state_code(r_state);
    assign o_kill               = r_kill;
    assign o_precharge_done     = r_pre;
    assign o_contactor_done     = r_cc;
    assign o_monitor_error_mask = r_err;

    `BPS_ASSERT_NOW(a_kill_isolates, i_clk, i_rst_n, o_valid && o_kill,
        o_relay_mask == 5'h00 && o_supervisor_state == bps_pkg::CODE_SELFCHECK
        && !o_precharge_done && !o_contactor_done, "kill without full isolation")
    `BPS_ASSERT_NOW(a_contactor_normal, i_clk, i_rst_n, o_valid && o_contactor_done,
        o_supervisor_state == bps_pkg::CODE_NORMAL && o_relay_mask[bps_pkg::RL_MAIN_BIT]
        && !o_relay_mask[bps_pkg::RL_PRE_BIT], "contactor closed outside normal")
    `BPS_ASSERT_NOW(a_step_range, i_clk, i_rst_n, 1'b1, r_step < bps_pkg::STEP_LAST,
        "monitor step out of range")
    `BPS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, r_in_valid && o_valid && i_stall,
        "stall without full pipeline")
    `BPS_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !adv,
        $stable(r_state) && $stable(r_relay) && $stable(r_step),
        "state changed without a request")

endmodule
